/* hdl/alcs_pkg.sv */
// Shared types and constants for the auto levels contrast stretch block.
`timescale 1ns / 1ps

package alcs_pkg;

    localparam int NUM_LANES = 3;
    localparam int PIX_W     = 8;
    localparam int DIV_STEPS = 8;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_MAP     = 1'b1;

    localparam logic [2:0] REG_THREE_CHANNELS = 3'd0;
    localparam logic [2:0] REG_AUTO_MODE      = 3'd1;
    localparam logic [2:0] REG_LOWER_BOUND_0  = 3'd2;
    localparam logic [2:0] REG_UPPER_BOUND_0  = 3'd3;
    localparam logic [2:0] REG_LOWER_BOUND_1  = 3'd4;
    localparam logic [2:0] REG_UPPER_BOUND_1  = 3'd5;
    localparam logic [2:0] REG_LOWER_BOUND_2  = 3'd6;
    localparam logic [2:0] REG_UPPER_BOUND_2  = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic measure;
        logic first;
    } lane_ctrl_t;

endpackage

/* hdl/auto_levels_contrast_stretch.sv */
// Top level of the per-channel auto levels contrast stretch block.
//
// Input channel: in_valid / in_stall with cmd, first_of_frame and pixel_0..2.
// A measure item (cmd 0) folds the pixel into the running per-channel
// min/max in its accept cycle and gives no result; the next item may follow
// in the next cycle. A map item (cmd 1) gives one result on out_valid /
// out_stall with mapped_0..2.
// A map item runs through three channel lanes in parallel, each with a
// restoring divider producing one quotient bit per cycle. The 8 divider
// steps set the cost: a map item holds the input through acceptance, the
// 8 steps and the transfer into the output register, and its result
// appears at the output once that transfer is made.
// The output register lets the next item be accepted while a result waits.
// When the receiver stalls, the result holds; a following map item finishes
// its division and then waits until the output register is free.
// Configuration: cfg_write with cfg_index and cfg_data, one register per write.
// Reset sets three channels, manual mode, bounds 0..255, min 255 and max 0,
// and leaves both channels empty.
`timescale 1ns / 1ps

module auto_levels_contrast_stretch
    import alcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  logic             first_of_frame,
    input  logic [PIX_W-1:0] pixel_0,
    input  logic [PIX_W-1:0] pixel_1,
    input  logic [PIX_W-1:0] pixel_2,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] mapped_0,
    output logic [PIX_W-1:0] mapped_1,
    output logic [PIX_W-1:0] mapped_2
);

    logic                            three_ch_reg;
    logic                            auto_reg;
    logic [NUM_LANES-1:0][PIX_W-1:0] lower_reg;
    logic [NUM_LANES-1:0][PIX_W-1:0] upper_reg;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            accept;
    logic                            load_out;
    logic                            free;
    lane_ctrl_t                      ctrl;
    logic [NUM_LANES-1:0][PIX_W-1:0] pixels;
    logic [NUM_LANES-1:0][PIX_W-1:0] lane_result;
    logic [NUM_LANES-1:0]            lane_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_ch_reg <= 1'b1;
            auto_reg     <= 1'b0;
            lower_reg    <= {NUM_LANES{PIX_MIN}};
            upper_reg    <= {NUM_LANES{PIX_MAX}};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_THREE_CHANNELS: three_ch_reg <= cfg_data[0];
                REG_AUTO_MODE:      auto_reg     <= cfg_data[0];
                REG_LOWER_BOUND_0:  lower_reg[0] <= cfg_data;
                REG_UPPER_BOUND_0:  upper_reg[0] <= cfg_data;
                REG_LOWER_BOUND_1:  lower_reg[1] <= cfg_data;
                REG_UPPER_BOUND_1:  upper_reg[1] <= cfg_data;
                REG_LOWER_BOUND_2:  lower_reg[2] <= cfg_data;
                REG_UPPER_BOUND_2:  upper_reg[2] <= cfg_data;
                default:            three_ch_reg <= three_ch_reg;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        load_out     = 1'b0;
        ctrl.load    = accept && (cmd == CMD_MAP);
        ctrl.measure = accept && (cmd == CMD_MEASURE);
        ctrl.first   = first_of_frame;
        ctrl.step    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.load)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign pixels      = {pixel_2, pixel_1, pixel_0};
    assign lane_active = {three_ch_reg, three_ch_reg, 1'b1};

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        alcs_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .active    (lane_active[i]),
            .auto_mode (auto_reg),
            .pixel     (pixels[i]),
            .lower     (lower_reg[i]),
            .upper     (upper_reg[i]),
            .result    (lane_result[i])
        );
    end

    alcs_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load_out),
        .lane_result (lane_result),
        .out_stall   (out_stall),
        .free        (free),
        .out_valid   (out_valid),
        .mapped_0    (mapped_0),
        .mapped_1    (mapped_1),
        .mapped_2    (mapped_2)
    );

endmodule

/* hdl/alcs_lane.sv */
// One channel lane: running min/max tracking and an iterative stretch divider.
`timescale 1ns / 1ps

module alcs_lane
    import alcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic             active,
    input  logic             auto_mode,
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] lower,
    input  logic [PIX_W-1:0] upper,
    output logic [PIX_W-1:0] result
);

    logic [PIX_W-1:0]   min_reg, min_next;
    logic [PIX_W-1:0]   max_reg, max_next;
    logic [PIX_W-1:0]   lo, hi, diff, span;
    logic [2*PIX_W-1:0] prod;
    logic               special;
    logic [PIX_W-1:0]   special_val;
    logic               special_reg;
    logic [PIX_W-1:0]   sval_reg;
    logic [PIX_W-1:0]   span_reg;
    logic [PIX_W-1:0]   rem_reg, rem_next;
    logic [PIX_W-1:0]   quo_reg, quo_next;
    logic [PIX_W:0]     trial, trial_diff;
    logic               ge;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.measure && active)
        begin
            if (ctrl.first)
            begin
                min_next = pixel;
                max_next = pixel;
            end
            else
            begin
                if (pixel < min_reg)
                begin
                    min_next = pixel;
                end
                if (pixel > max_reg)
                begin
                    max_next = pixel;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= PIX_MAX;
            max_reg <= PIX_MIN;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign lo   = auto_mode ? min_reg : lower;
    assign hi   = auto_mode ? max_reg : upper;
    assign diff = pixel - lo;
    assign span = hi - lo;
    assign prod = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};

    always_comb
    begin
        special     = 1'b1;
        special_val = PIX_MIN;
        if (!active || (pixel < lo))
        begin
            special_val = PIX_MIN;
        end
        else if ((pixel > hi) || (span == PIX_MIN))
        begin
            special_val = PIX_MAX;
        end
        else
        begin
            special = 1'b0;
        end
    end

    // Restoring division, one quotient bit per step; the quotient never exceeds 255.
    assign trial      = {rem_reg, quo_reg[PIX_W-1]};
    assign trial_diff = trial - {1'b0, span_reg};
    assign ge         = (trial >= {1'b0, span_reg});

    always_comb
    begin
        rem_next = ge ? trial_diff[PIX_W-1:0] : trial[PIX_W-1:0];
        quo_next = {quo_reg[PIX_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            special_reg <= special;
            sval_reg    <= special_val;
            span_reg    <= span;
            rem_reg     <= prod[2*PIX_W-1:PIX_W];
            quo_reg     <= prod[PIX_W-1:0];
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign result = special_reg ? sval_reg : quo_reg;

endmodule

/* hdl/alcs_merge.sv */
// Merging stage: gathers the lane results into the registered output item.
`timescale 1ns / 1ps

module alcs_merge
    import alcs_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [NUM_LANES-1:0][PIX_W-1:0] lane_result,
    input  logic                           out_stall,
    output logic                           free,
    output logic                           out_valid,
    output logic [PIX_W-1:0]               mapped_0,
    output logic [PIX_W-1:0]               mapped_1,
    output logic [PIX_W-1:0]               mapped_2
);

    logic                            valid_reg, valid_next;
    logic [NUM_LANES-1:0][PIX_W-1:0] data_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= lane_result;
        end
    end

    assign out_valid = valid_reg;
    assign mapped_0  = data_reg[0];
    assign mapped_1  = data_reg[1];
    assign mapped_2  = data_reg[2];

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the auto levels contrast stretch block.
`timescale 1ns / 1ps

module tb_top;
    import alcs_pkg::*;

    localparam int SETTLE_CYCLES = 15;
    localparam int QUIET_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 880;

    typedef struct packed {
        logic             cmd;
        logic             first;
        logic [PIX_W-1:0] px0;
        logic [PIX_W-1:0] px1;
        logic [PIX_W-1:0] px2;
    } pix_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] m0;
        logic [PIX_W-1:0] m1;
        logic [PIX_W-1:0] m2;
    } stretch_res_t;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             cfg_write      = 1'b0;
    logic [2:0]       cfg_index      = REG_THREE_CHANNELS;
    logic [PIX_W-1:0] cfg_data       = PIX_MIN;
    logic             in_valid       = 1'b0;
    logic             in_stall;
    logic             cmd            = CMD_MEASURE;
    logic             first_of_frame = 1'b0;
    logic [PIX_W-1:0] pixel_0        = PIX_MIN;
    logic [PIX_W-1:0] pixel_1        = PIX_MIN;
    logic [PIX_W-1:0] pixel_2        = PIX_MIN;
    logic             out_valid;
    logic             out_stall      = 1'b0;
    logic [PIX_W-1:0] mapped_0;
    logic [PIX_W-1:0] mapped_1;
    logic [PIX_W-1:0] mapped_2;

    logic             lvl_three = 1'b1;
    logic             lvl_auto  = 1'b0;
    logic [PIX_W-1:0] lvl_lo [3] = '{PIX_MIN, PIX_MIN, PIX_MIN};
    logic [PIX_W-1:0] lvl_hi [3] = '{PIX_MAX, PIX_MAX, PIX_MAX};
    logic [PIX_W-1:0] run_min [3] = '{PIX_MAX, PIX_MAX, PIX_MAX};
    logic [PIX_W-1:0] run_max [3] = '{PIX_MIN, PIX_MIN, PIX_MIN};

    pix_item_t    pend_px [$];
    stretch_res_t want_q [$];
    pix_item_t    cur_px;
    int           send_gap  = 0;
    int           rcv_gap   = 0;
    int           hold_left = 0;
    int           quiet     = 0;
    int           errors    = 0;
    bit           idle_on   = 1'b0;
    bit           hold_req  = 1'b0;
    bit           hold_seen = 1'b0;

    auto_levels_contrast_stretch i_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] level_stretch(int v, int lo, int hi);
        if (v < lo)
            return PIX_MIN;
        if (v > hi)
            return PIX_MAX;
        if (hi == lo)
            return PIX_MAX;
        return 8'((255 * (v - lo)) / (hi - lo));
    endfunction

    function automatic void predict_pixel(pix_item_t it);
        logic [PIX_W-1:0] px [3];
        logic [PIX_W-1:0] r [3];
        int               nch;
        stretch_res_t     res;
        px[0] = it.px0;
        px[1] = it.px1;
        px[2] = it.px2;
        nch = lvl_three ? 3 : 1;
        if (it.cmd == CMD_MEASURE)
        begin
            for (int c = 0; c < nch; c++)
            begin
                if (it.first || px[c] < run_min[c])
                    run_min[c] = px[c];
                if (it.first || px[c] > run_max[c])
                    run_max[c] = px[c];
            end
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (c >= nch)
                    r[c] = PIX_MIN;
                else if (lvl_auto)
                    r[c] = level_stretch(int'(px[c]), int'(run_min[c]), int'(run_max[c]));
                else
                    r[c] = level_stretch(int'(px[c]), int'(lvl_lo[c]), int'(lvl_hi[c]));
            end
            res = '{m0: r[0], m1: r[1], m2: r[2]};
            want_q.insert(want_q.size(), res);
        end
    endfunction

    function automatic void queue_pixel(logic c, logic f, logic [PIX_W-1:0] p0,
                                        logic [PIX_W-1:0] p1, logic [PIX_W-1:0] p2);
        pix_item_t it;
        it = '{cmd: c, first: f, px0: p0, px1: p1, px2: p2};
        pend_px.insert(pend_px.size(), it);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [PIX_W-1:0] val);
        int k;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_THREE_CHANNELS)
            lvl_three = val[0];
        else if (idx == REG_AUTO_MODE)
            lvl_auto = val[0];
        else
        begin
            k = int'(idx) - int'(REG_LOWER_BOUND_0);
            if (k % 2 == 1)
                lvl_hi[k / 2] = val;
            else
                lvl_lo[k / 2] = val;
        end
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pend_px.size() != 0 || in_valid || want_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : px_sender
        if (in_valid && !in_stall)
            predict_pixel(cur_px);
        if (!in_valid || !in_stall)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pend_px.size() != 0)
            begin
                cur_px = pend_px.pop_front();
                in_valid       <= 1'b1;
                cmd            <= cur_px.cmd;
                first_of_frame <= cur_px.first;
                pixel_0        <= cur_px.px0;
                pixel_1        <= cur_px.px1;
                pixel_2        <= cur_px.px2;
                send_gap = idle_on ? gap_len() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : res_sink
        stretch_res_t want;
        if (out_valid && !out_stall)
        begin
            if (want_q.size() == 0)
            begin
                $error("result with no map item waiting: %0d %0d %0d",
                       mapped_0, mapped_1, mapped_2);
                errors++;
            end
            else
            begin
                want = want_q.pop_front();
                if (mapped_0 !== want.m0)
                begin
                    $error("mapped_0 expected %0d actual %0d", want.m0, mapped_0);
                    errors++;
                end
                if (mapped_1 !== want.m1)
                begin
                    $error("mapped_1 expected %0d actual %0d", want.m1, mapped_1);
                    errors++;
                end
                if (mapped_2 !== want.m2)
                begin
                    $error("mapped_2 expected %0d actual %0d", want.m2, mapped_2);
                    errors++;
                end
            end
        end
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rcv_gap > 0)
        begin
            rcv_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            rcv_gap = idle_on ? gap_len() : 0;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin : stimulus
        pix_item_t frame [$];
        pix_item_t it;
        int        sent;
        int        n;
        int        len;
        int        sel;
        int        a;
        int        b;
        int        lo_b;
        int        hi_b;
        int        base [3];
        int        span [3];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        queue_pixel(CMD_MAP, 1'b0, 8'd0, 8'd0, 8'd0);
        queue_pixel(CMD_MAP, 1'b0, 8'd255, 8'd255, 8'd255);
        queue_pixel(CMD_MAP, 1'b1, 8'd1, 8'd128, 8'd254);
        wait_drained();

        // Auto mapping before any measure runs on the reset minimum and maximum.
        write_reg(REG_AUTO_MODE, 8'd1);
        close_writes();
        queue_pixel(CMD_MAP, 1'b0, 8'd255, 8'd0, 8'd254);
        queue_pixel(CMD_MEASURE, 1'b1, 8'd10, 8'd20, 8'd30);
        queue_pixel(CMD_MEASURE, 1'b0, 8'd200, 8'd5, 8'd30);
        queue_pixel(CMD_MEASURE, 1'b0, 8'd50, 8'd250, 8'd30);
        queue_pixel(CMD_MAP, 1'b0, 8'd10, 8'd5, 8'd30);
        queue_pixel(CMD_MAP, 1'b0, 8'd200, 8'd250, 8'd29);
        queue_pixel(CMD_MAP, 1'b1, 8'd105, 8'd127, 8'd31);
        wait_drained();

        // A one-channel measure must leave channels 1 and 2 untouched.
        write_reg(REG_THREE_CHANNELS, 8'd0);
        close_writes();
        queue_pixel(CMD_MEASURE, 1'b1, 8'd100, 8'd7, 8'd7);
        queue_pixel(CMD_MEASURE, 1'b0, 8'd150, 8'd9, 8'd9);
        queue_pixel(CMD_MAP, 1'b0, 8'd125, 8'd77, 8'd88);
        wait_drained();
        write_reg(REG_THREE_CHANNELS, 8'd1);
        close_writes();
        queue_pixel(CMD_MAP, 1'b0, 8'd100, 8'd5, 8'd30);
        wait_drained();

        write_reg(REG_AUTO_MODE, 8'd0);
        write_reg(REG_LOWER_BOUND_0, 8'd200);
        write_reg(REG_UPPER_BOUND_0, 8'd100);
        write_reg(REG_LOWER_BOUND_1, 8'd77);
        write_reg(REG_UPPER_BOUND_1, 8'd77);
        write_reg(REG_LOWER_BOUND_2, 8'd0);
        write_reg(REG_UPPER_BOUND_2, 8'd0);
        close_writes();
        queue_pixel(CMD_MAP, 1'b0, 8'd150, 8'd77, 8'd0);
        queue_pixel(CMD_MAP, 1'b0, 8'd199, 8'd76, 8'd1);
        queue_pixel(CMD_MAP, 1'b0, 8'd201, 8'd78, 8'd255);
        wait_drained();

        // The receiver holds off for a long stretch while map items keep coming.
        idle_on = 1'b0;
        hold_req = !hold_req;
        repeat (12)
            queue_pixel(CMD_MAP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_reg(REG_THREE_CHANNELS, 8'($urandom_range(0, 3) != 0));
            write_reg(REG_AUTO_MODE, 8'($urandom_range(0, 1)));
            for (int c = 0; c < 3; c++)
            begin
                sel = $urandom_range(0, 6);
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
                case (sel)
                    0:
                    begin
                        lo_b = 0;
                        hi_b = 255;
                    end
                    1:
                    begin
                        lo_b = (a < b) ? a : b;
                        hi_b = (a < b) ? b : a;
                    end
                    2:
                    begin
                        lo_b = (a > b) ? a : b;
                        hi_b = (a > b) ? b : a;
                    end
                    3:
                    begin
                        lo_b = a;
                        hi_b = a;
                    end
                    4:
                    begin
                        lo_b = 255;
                        hi_b = 0;
                    end
                    5:
                    begin
                        lo_b = 255;
                        hi_b = 255;
                    end
                    default:
                    begin
                        lo_b = a;
                        hi_b = b;
                    end
                endcase
                write_reg(3'(REG_LOWER_BOUND_0 + 2 * c), 8'(lo_b));
                write_reg(3'(REG_UPPER_BOUND_0 + 2 * c), 8'(hi_b));
            end
            close_writes();
            idle_on = ($urandom_range(0, 3) != 0);

            n = 0;
            while (n < 50)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    queue_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                    n++;
                end
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    for (int c = 0; c < 3; c++)
                    begin
                        base[c] = $urandom_range(0, 255);
                        span[c] = $urandom_range(0, 255 - base[c]);
                    end
                    frame.delete();
                    for (int i = 0; i < len; i++)
                    begin
                        it.cmd   = CMD_MEASURE;
                        it.first = (i == 0);
                        it.px0   = 8'(base[0] + $urandom_range(0, span[0]));
                        it.px1   = 8'(base[1] + $urandom_range(0, span[1]));
                        it.px2   = 8'(base[2] + $urandom_range(0, span[2]));
                        frame.insert(frame.size(), it);
                        pend_px.insert(pend_px.size(), it);
                    end
                    foreach (frame[i])
                    begin
                        it = frame[i];
                        it.cmd   = CMD_MAP;
                        it.first = 1'($urandom_range(0, 1));
                        if ($urandom_range(0, 9) == 0)
                            it.px0 = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 9) == 0)
                            it.px1 = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 9) == 0)
                            it.px2 = 8'($urandom_range(0, 255));
                        pend_px.insert(pend_px.size(), it);
                    end
                    n += 2 * len;
                end
            end
            sent += n;
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
